FILE: hdl/ffa_pkg.sv
// ffa_pkg: shared constants and types for the first-fit free region allocator
// used by ffa_cell and first_fit_free_region_allocator
package ffa_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int ADDRESS_BITS  = 16;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef logic [ADDRESS_BITS-1:0] t_addr;
    typedef logic [CNT_W-1:0]        t_cnt;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // per-cycle command broadcast to every cell
    typedef enum logic [4:0] {
        C_HOLD   = 5'b00001,
        C_UPDATE = 5'b00010,
        C_SHL    = 5'b00100,
        C_SHR    = 5'b01000,
        C_MRG    = 5'b10000
    } t_cmd;

    typedef struct packed {
        t_cmd  cmd;
        t_cnt  pos;
        t_addr start;
        t_addr len;
    } t_ctl;

    typedef struct packed {
        t_addr start;
        t_addr len;
    } t_ent;
endpackage

FILE: hdl/ffa_cell.sv
// ffa_cell: one table entry of the free region table
// depends on ffa_pkg; neighbors exchange entries for insert and delete shifts
module ffa_cell (
    input  logic          i_clk,
    input  ffa_pkg::t_cnt i_idx,
    input  ffa_pkg::t_ctl i_ctl,
    input  ffa_pkg::t_ent i_left,
    input  ffa_pkg::t_ent i_right,
    output ffa_pkg::t_ent o_ent
);
    import ffa_pkg::*;
    t_ent r_ent;
    t_ent n_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_ctl.cmd)
            C_UPDATE: begin
                if (i_idx == i_ctl.pos) begin
                    n_ent.start = i_ctl.start;
                    n_ent.len   = i_ctl.len;
                end
            end
            C_SHL: begin
                if (i_idx >= i_ctl.pos) n_ent = i_right;
            end
            C_SHR: begin
                if (i_idx > i_ctl.pos) n_ent = i_left;
                else if (i_idx == i_ctl.pos) begin
                    n_ent.start = i_ctl.start;
                    n_ent.len   = i_ctl.len;
                end
            end
            C_MRG: begin
                if (i_idx > i_ctl.pos) n_ent = i_right;
                else if (i_idx == i_ctl.pos) begin
                    n_ent.start = i_ctl.start;
                    n_ent.len   = i_ctl.len;
                end
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;
endmodule

FILE: hdl/first_fit_free_region_allocator.sv
// first_fit_free_region_allocator: top level, sequencer over a chain of table cells
// depends on ffa_pkg and ffa_cell
//
// Usage: requests enter on the i_ channel (operation, region_address,
// region_length) under i_valid / o_stall; one result per request leaves on
// the o_ channel (success, granted_address) under o_valid / i_stall.
// Operation 0 allocates first fit by address; operation 1 releases a region
// and merges it with adjacent free neighbors.
// Sequence: a request is taken into the input registers, all cells compare
// in parallel and the match vectors register, the decision is made and the
// cell row updates or shifts by one place while the result goes to a
// staging register, and the result then moves to the output register. One
// request at a time: o_stall drops only once the staging register is empty,
// so a new request is taken only after the last result has left staging.
// Reset: the table is empty, no result is pending, o_stall is low.
// Receiver stall: the result holds in its output register; one more
// request may be accepted and processed, then o_stall stays high until
// the output is taken.
module first_fit_free_region_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  ffa_pkg::t_addr       i_region_address,
    input  ffa_pkg::t_addr       i_region_length,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_success,
    output ffa_pkg::t_addr       o_granted_address
);
    import ffa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_op;
    t_addr  r_addr, r_len;
    t_ent   ents [TABLE_ENTRIES];
    t_ctl   ctl;

    // compare stage results
    logic [TABLE_ENTRIES-1:0] fit, le;
    logic [TABLE_ENTRIES-1:0] r_fit, r_le;

    // result staging
    logic  r_hv, r_ov, r_res_ok, r_out_ok;
    t_addr r_res_a, r_out_a;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            t_ent left_e, right_e;
            if (g == 0) begin : g_l
                assign left_e = '0;
            end else begin : g_lm
                assign left_e = ents[g-1];
            end
            if (g == TABLE_ENTRIES - 1) begin : g_r
                assign right_e = '0;
            end else begin : g_rm
                assign right_e = ents[g+1];
            end
            ffa_cell u_cell (
                .i_clk  (i_clk),
                .i_idx  (t_cnt'(g)),
                .i_ctl  (ctl),
                .i_left (left_e),
                .i_right(right_e),
                .o_ent  (ents[g])
            );
            assign fit[g] = (t_cnt'(g) < r_count) && (ents[g].len >= r_len);
            assign le[g]  = (t_cnt'(g) < r_count) && (ents[g].start <= r_addr);
        end
    endgenerate

    // decision from registered compare vectors
    logic     any_fit;
    t_cnt     fpos, rpos;
    t_ent     fe, pe, se;
    logic     pred_adj, succ_adj, rel_ok;
    logic [ADDRESS_BITS:0] end_a, pend, tot_p, tot_s, tot_b;
    logic     dec_ok;
    t_addr    dec_a;

    // first fit place: lowest live entry long enough; release place: first live entry whose start exceeds the address
    always_comb begin
        any_fit = |r_fit;
        fpos = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (r_fit[k]) fpos = t_cnt'(k);
        end
        rpos = r_count;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if ((t_cnt'(k) < r_count) && !r_le[k]) rpos = t_cnt'(k);
        end
    end

    assign fe = ents[fpos[IDX_W-1:0]];
    assign pe = (rpos != '0) ? ents[IDX_W'(rpos - t_cnt'(1))] : '0;
    assign se = (rpos < r_count) ? ents[rpos[IDX_W-1:0]] : '0;
    assign end_a = {1'b0, r_addr} + {1'b0, r_len};
    assign pend  = {1'b0, pe.start} + {1'b0, pe.len};
    assign pred_adj = (rpos != '0) && (pend == {1'b0, r_addr});
    assign succ_adj = (rpos < r_count) && (end_a == {1'b0, se.start});
    assign tot_p = {1'b0, pe.len} + {1'b0, r_len};
    assign tot_s = {1'b0, se.len} + {1'b0, r_len};
    assign tot_b = tot_p + {1'b0, se.len};

    always_comb begin
        ctl.cmd   = C_HOLD;
        ctl.pos   = '0;
        ctl.start = '0;
        ctl.len   = '0;
        n_count   = r_count;
        dec_ok    = 1'b0;
        dec_a     = '0;
        if (r_state == S_DEC) begin
            if (r_len == '0) begin
                dec_ok = 1'b0;
            end else if (r_op == OP_ALLOC) begin
                if (any_fit) begin
                    dec_ok = 1'b1;
                    dec_a  = fe.start;
                    ctl.pos = fpos;
                    if (fe.len == r_len) begin
                        ctl.cmd = C_SHL;
                        n_count = r_count - t_cnt'(1);
                    end else begin
                        ctl.cmd   = C_UPDATE;
                        ctl.start = fe.start + r_len;
                        ctl.len   = fe.len - r_len;
                    end
                end
            end else if (!end_a[ADDRESS_BITS] || end_a[ADDRESS_BITS-1:0] == '0) begin
                if (pred_adj && succ_adj) begin
                    if (!tot_b[ADDRESS_BITS] && tot_b <= {1'b0, {ADDRESS_BITS{1'b1}}}) begin
                        dec_ok = 1'b1;
                        // rewrite predecessor, drop successor
                        ctl.cmd   = C_MRG;
                        ctl.pos   = rpos - t_cnt'(1);
                        ctl.start = pe.start;
                        ctl.len   = tot_b[ADDRESS_BITS-1:0];
                        n_count   = r_count - t_cnt'(1);
                    end
                end else if (pred_adj) begin
                    if (!tot_p[ADDRESS_BITS]) begin
                        dec_ok = 1'b1;
                        ctl.cmd   = C_UPDATE;
                        ctl.pos   = rpos - t_cnt'(1);
                        ctl.start = pe.start;
                        ctl.len   = tot_p[ADDRESS_BITS-1:0];
                    end
                end else if (succ_adj) begin
                    if (!tot_s[ADDRESS_BITS]) begin
                        dec_ok = 1'b1;
                        ctl.cmd   = C_UPDATE;
                        ctl.pos   = rpos;
                        ctl.start = r_addr;
                        ctl.len   = tot_s[ADDRESS_BITS-1:0];
                    end
                end else if (r_count < t_cnt'(TABLE_ENTRIES)) begin
                    dec_ok = 1'b1;
                    ctl.cmd   = C_SHR;
                    ctl.pos   = rpos;
                    ctl.start = r_addr;
                    ctl.len   = r_len;
                    n_count   = r_count + t_cnt'(1);
                end
            end
        end
    end

    // a both-sides merge writes the merged entry at pos and shifts the
    // cells above it left by one
    logic in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ov && !i_stall;
    assign o_stall = (r_state != S_IDLE) || r_hv;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_CMP;
            S_CMP:  n_state = S_DEC;
            S_DEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DEC) r_hv <= 1'b1;
            if (r_hv && (!r_ov || out_acc)) begin
                r_hv <= (r_state == S_DEC);
                r_ov <= 1'b1;
            end else if (out_acc) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_operation;
            r_addr <= i_region_address;
            r_len  <= i_region_length;
        end
        if (r_state == S_CMP) begin
            r_fit <= fit;
            r_le  <= le;
        end
        if (r_state == S_DEC) begin
            r_res_ok <= dec_ok;
            r_res_a  <= dec_a;
        end
        if (r_hv && (!r_ov || out_acc)) begin
            r_out_ok <= r_res_ok;
            r_out_a  <= r_res_a;
        end
    end

    assign o_valid           = r_ov;
    assign o_success         = r_out_ok;
    assign o_granted_address = r_out_a;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(TABLE_ENTRIES)) else $error("entry count overflow");
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DEC) |=> $stable(r_count)) else $error("count moved outside decide");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accepting while busy");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_success) |-> (o_granted_address == '0)) else $error("address on failure");
endmodule
